/* rtl/fud_pkg.sv */
// ----------------------------------------------------------------------------
// fud_pkg: shared types and constants for the upload deframer
// Word layouts, phase codes and header geometry.
// ----------------------------------------------------------------------------
package fud_pkg;

  // header geometry: big-endian size, big-endian name length, padding
  localparam int unsigned HdrBytes  = 16;
  localparam int unsigned SizeBytes = 8;
  localparam int unsigned LenEnd    = 12;

  localparam int unsigned CountW = 32;
  localparam int unsigned SizeW  = 64;

  // separator characters in names
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharBackslash = 8'h5C;

  // phase codes as reported in the result word
  localparam logic [1:0] PhHeader = 2'd0;
  localparam logic [1:0] PhName   = 2'd1;
  localparam logic [1:0] PhData   = 2'd2;
  localparam logic [1:0] PhDrop   = 2'd3;

  // session state, one-hot
  typedef enum logic [2:0] {
    ST_HEADER = 3'b001,
    ST_NAME   = 3'b010,
    ST_DATA   = 3'b100
  } state_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       drop;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        byte_out;
    logic [1:0]        phase;
    logic              header_done;
    logic [SizeW-1:0]  upload_size;
    logic [CountW-1:0] name_length;
    logic [CountW-1:0] name_index;
    logic              name_done;
    logic [CountW-1:0] base_start;
    logic              file_done;
  } out_word_t;

endpackage

/* rtl/file_upload_deframer.sv */
// ----------------------------------------------------------------------------
// file_upload_deframer: byte-serial deframer for a file upload stream
// Splits a byte stream into header, name and file data and tags each byte.
// ----------------------------------------------------------------------------
// One received byte goes in per word and exactly one tagged word comes out.
// A session is a 16-byte header (big-endian 64-bit file size, big-endian
// 32-bit name length, 4 padding bytes), then the name bytes, then the file
// bytes. The last name byte reports the offset just past the last '/' or '\'
// and the last file byte raises file_done, after which the block expects a
// new header. Empty names and empty files complete on the byte that ends the
// previous part. A word with drop set clears the session and comes out with
// phase 3 and all other fields zero. Throughput is one word per cycle while
// the output is not stalled: a word sits in the input stage while the phase
// logic and the 64-bit file counter compare run, then in the output register.
// Both stages advance independently, so a stalled output does not stop the
// input until both stages are full.
module file_upload_deframer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  fud_pkg::in_word_t      in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output fud_pkg::out_word_t     out_word_o
);

  // input stage
  logic               stage_valid_q;
  fud_pkg::in_word_t  stage_word_q;

  // output register
  logic               out_valid_q;
  fud_pkg::out_word_t out_word_q;

  // session state
  fud_pkg::state_e                state_q, state_d;
  logic [fud_pkg::CountW-1:0]     part_count_q, part_count_d;
  logic [fud_pkg::SizeW-1:0]      size_q, size_d;
  logic [fud_pkg::CountW-1:0]     len_q, len_d;
  logic [fud_pkg::SizeW-1:0]      data_count_q, data_count_d;
  logic [fud_pkg::CountW-1:0]     slash_base_q, slash_base_d;

  fud_pkg::out_word_t res_d;

  logic out_free;   // output register can take a word this cycle
  logic advance;    // stage word is processed and moves to the output

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = stage_valid_q && out_free;
  assign in_ready_o = !stage_valid_q || advance;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // phase logic on the staged word
  always_comb begin
    logic [7:0]                 b;
    logic [fud_pkg::CountW-1:0] part_inc;
    logic [fud_pkg::SizeW-1:0]  data_inc;
    logic                       show_hdr;
    logic                       finish;

    b        = stage_word_q.rx_byte;
    part_inc = part_count_q + fud_pkg::CountW'(1);
    data_inc = data_count_q + fud_pkg::SizeW'(1);
    show_hdr = 1'b1;
    finish   = 1'b0;

    state_d      = state_q;
    part_count_d = part_count_q;
    size_d       = size_q;
    len_d        = len_q;
    data_count_d = data_count_q;
    slash_base_d = slash_base_q;

    res_d          = '0;
    res_d.byte_out = b;

    unique case (state_q)
      fud_pkg::ST_NAME: begin
        res_d.phase      = fud_pkg::PhName;
        res_d.name_index = part_count_q;
        if (b == fud_pkg::CharSlash || b == fud_pkg::CharBackslash) begin
          slash_base_d = part_inc;
        end
        part_count_d = part_inc;
        if (part_inc == len_q) begin
          res_d.name_done  = 1'b1;
          res_d.base_start = slash_base_d;
          part_count_d     = '0;
          state_d          = fud_pkg::ST_DATA;
          if (size_q == '0) begin
            res_d.file_done = 1'b1;
            finish          = 1'b1;
          end
        end
      end
      fud_pkg::ST_DATA: begin
        res_d.phase  = fud_pkg::PhData;
        data_count_d = data_inc;
        if (data_inc == size_q) begin
          res_d.file_done = 1'b1;
          finish          = 1'b1;
        end
      end
      default: begin
        // header phase: shift size bytes, then length bytes, skip padding
        res_d.phase = fud_pkg::PhHeader;
        if (part_count_q < fud_pkg::CountW'(fud_pkg::SizeBytes)) begin
          size_d = {size_q[fud_pkg::SizeW-9:0], b};
        end else if (part_count_q < fud_pkg::CountW'(fud_pkg::LenEnd)) begin
          len_d = {len_q[fud_pkg::CountW-9:0], b};
        end
        part_count_d = part_inc;
        if (part_inc >= fud_pkg::CountW'(fud_pkg::HdrBytes)) begin
          res_d.header_done = 1'b1;
          part_count_d      = '0;
          slash_base_d      = '0;
          data_count_d      = '0;
          state_d           = fud_pkg::ST_NAME;
          if (len_d == '0) begin
            // empty name ends at header end, base offset stays zero
            res_d.name_done = 1'b1;
            state_d         = fud_pkg::ST_DATA;
            if (size_d == '0) begin
              res_d.file_done = 1'b1;
              finish          = 1'b1;
            end
          end
        end else begin
          show_hdr = 1'b0;
        end
      end
    endcase

    // decoded header shows once complete, including on the finishing byte
    res_d.upload_size = show_hdr ? size_d : '0;
    res_d.name_length = show_hdr ? len_d : '0;

    if (finish || stage_word_q.drop) begin
      state_d      = fud_pkg::ST_HEADER;
      part_count_d = '0;
      size_d       = '0;
      len_d        = '0;
      data_count_d = '0;
      slash_base_d = '0;
    end

    if (stage_word_q.drop) begin
      // connection closed: byte ignored, everything but the phase is zero
      res_d       = '0;
      res_d.phase = fud_pkg::PhDrop;
    end
  end

  // handshake control and session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q       <= fud_pkg::ST_HEADER;
      part_count_q  <= '0;
      size_q        <= '0;
      len_q         <= '0;
      data_count_q  <= '0;
      slash_base_q  <= '0;
    end else begin
      if (in_ready_o) begin
        stage_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= stage_valid_q;
      end
      if (advance) begin
        state_q      <= state_d;
        part_count_q <= part_count_d;
        size_q       <= size_d;
        len_q        <= len_d;
        data_count_q <= data_count_d;
        slash_base_q <= slash_base_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stage_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= res_d;
    end
  end

  // a completed file always returns the session to the header phase
  a_done_to_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.file_done |=> state_q == fud_pkg::ST_HEADER)
    else $error("file_done word did not return to header phase");

  // the header byte counter never runs past the header
  a_header_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fud_pkg::ST_HEADER |->
      part_count_q < fud_pkg::CountW'(fud_pkg::HdrBytes))
    else $error("header byte count out of range");

  // header completion is only ever tagged on header bytes
  a_hdr_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.header_done |->
      out_word_q.phase == fud_pkg::PhHeader)
    else $error("header_done outside header phase");

  // a name completes only at header end or on a name byte
  a_name_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.name_done |->
      (out_word_q.phase == fud_pkg::PhName ||
       (out_word_q.phase == fud_pkg::PhHeader && out_word_q.header_done)))
    else $error("name_done in unexpected phase");

endmodule
